[hw/rtl/dd_pkg.sv]
package dd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 22;
    localparam int ORD_W    = 23;
    localparam int DOY_W    = 9;
    localparam int EXTRA_W  = 14;
    localparam int LEAPS_W  = 13;

    // x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every x below 43699.
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [ORD_W-1:0] t_ordinal;

    // Days in the months before month m of a common year.
    function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] days;
        unique case (m)
            4'd0, 4'd1: days = 9'd0;
            4'd2:       days = 9'd31;
            4'd3:       days = 9'd59;
            4'd4:       days = 9'd90;
            4'd5:       days = 9'd120;
            4'd6:       days = 9'd151;
            4'd7:       days = 9'd181;
            4'd8:       days = 9'd212;
            4'd9:       days = 9'd243;
            4'd10:      days = 9'd273;
            4'd11:      days = 9'd304;
            4'd12:      days = 9'd334;
            default:    days = 9'd365;
        endcase
        return days;
    endfunction

endpackage

[hw/rtl/dd_ordinal.sv]
module dd_ordinal (
    input  logic                        i_clk,
    input  logic [2:0]                  i_en,
    input  logic [dd_pkg::YEAR_W-1:0]   i_year,
    input  logic [dd_pkg::MONTH_W-1:0]  i_month,
    input  logic [dd_pkg::DAY_W-1:0]    i_day,
    output dd_pkg::t_ordinal            o_ordinal
);
    import dd_pkg::*;

    localparam int PROD_W = 28;

    // Stage 1: quotients by 100 and 400 through reciprocal products.
    logic [YEAR_W-1:0]  r_s1_year;
    logic [MONTH_W-1:0] r_s1_month;
    logic [DAY_W-1:0]   r_s1_day;
    logic [7:0]         r_s1_q99;
    logic [5:0]         r_s1_q399;
    logic [7:0]         r_s1_qy;

    logic [YEAR_W:0]    y_plus_99;
    logic [YEAR_W:0]    y_plus_399;
    logic [PROD_W-1:0]  prod_99;
    logic [PROD_W-1:0]  prod_399;
    logic [PROD_W-1:0]  prod_y;

    assign y_plus_99  = {1'b0, i_year} + (YEAR_W+1)'(99);
    assign y_plus_399 = {1'b0, i_year} + (YEAR_W+1)'(399);
    assign prod_99    = PROD_W'(y_plus_99) * PROD_W'(RECIP_100);
    assign prod_399   = PROD_W'(y_plus_399[YEAR_W:2]) * PROD_W'(RECIP_100);
    assign prod_y     = PROD_W'(i_year) * PROD_W'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_year  <= i_year;
            r_s1_month <= i_month;
            r_s1_day   <= i_day;
            r_s1_q99   <= prod_99[RECIP_SHIFT+7:RECIP_SHIFT];
            r_s1_q399  <= prod_399[RECIP_SHIFT+5:RECIP_SHIFT];
            r_s1_qy    <= prod_y[RECIP_SHIFT+7:RECIP_SHIFT];
        end
    end

    // Stage 2: leap count, leap flag, day of year and whole-year days.
    logic [ORD_W-1:0]   r_s2_base;
    logic [EXTRA_W-1:0] r_s2_extra;

    logic [YEAR_W:0]    y_plus_3;
    logic [LEAPS_W-1:0] leaps;
    logic [YEAR_W-1:0]  qy_times_100;
    logic               is_leap;
    logic [DOY_W-1:0]   doy;

    assign y_plus_3     = {1'b0, r_s1_year} + (YEAR_W+1)'(3);
    assign leaps        = LEAPS_W'(y_plus_3[YEAR_W:2]) - LEAPS_W'(r_s1_q99)
                          + LEAPS_W'(r_s1_q399);
    assign qy_times_100 = YEAR_W'(r_s1_qy) * YEAR_W'(100);
    // A multiple of 100 is a leap year only when its quotient by 100 is a multiple of 4.
    assign is_leap      = (r_s1_year[1:0] == 2'b00)
                          && ((r_s1_year != qy_times_100) || (r_s1_qy[1:0] == 2'b00));
    assign doy          = days_before_month(r_s1_month) + DOY_W'(r_s1_day)
                          + DOY_W'(is_leap && (r_s1_month >= MONTH_W'(3)));

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s2_base  <= ORD_W'(r_s1_year) * ORD_W'(365);
            r_s2_extra <= EXTRA_W'(leaps) + EXTRA_W'(doy);
        end
    end

    // Stage 3: the ordinal itself.
    t_ordinal r_s3_ordinal;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s3_ordinal <= r_s2_base + ORD_W'(r_s2_extra);
        end
    end

    assign o_ordinal = r_s3_ordinal;

endmodule

[hw/rtl/date_difference_in_days_core.sv]
// Absolute day count between two Gregorian dates.
//
// Input channel: i_in_valid / o_in_ready with the two dates (year, month,
// day each). Output channel: o_out_valid / i_out_ready with o_day_count.
// A beat moves when valid and ready are both high at a rising clock edge.
//
// Each date is turned into a day ordinal in three stages (reciprocal
// products for the leap-year quotients, leap count and day of year, final
// sum); a fourth stage takes the absolute difference and saturates it at
// the full 22-bit value, which is registered as the result. One beat is
// taken every cycle while the receiver accepts, since every stage can
// load in the same cycle that its own beat moves on.
//
// When the receiver stalls, each stage holds its beat and the pipe keeps
// filling its empty stages; input ready drops only once all four stages
// are full. Synchronous active-low reset empties the pipe and holds input
// ready low while asserted.
module date_difference_in_days_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [dd_pkg::YEAR_W-1:0]   i_first_year,
    input  logic [dd_pkg::MONTH_W-1:0]  i_first_month,
    input  logic [dd_pkg::DAY_W-1:0]    i_first_day,
    input  logic [dd_pkg::YEAR_W-1:0]   i_second_year,
    input  logic [dd_pkg::MONTH_W-1:0]  i_second_month,
    input  logic [dd_pkg::DAY_W-1:0]    i_second_day,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [dd_pkg::COUNT_W-1:0]  o_day_count
);
    import dd_pkg::*;

    logic [3:0] r_v;
    logic [3:0] stage_en;

    // A stage loads when it is empty or its beat moves on this cycle.
    assign stage_en[3] = !r_v[3] || i_out_ready;
    assign stage_en[2] = !r_v[2] || stage_en[3];
    assign stage_en[1] = !r_v[1] || stage_en[2];
    assign stage_en[0] = !r_v[0] || stage_en[1];

    assign o_in_ready  = stage_en[0] && i_rst_n;
    assign o_out_valid = r_v[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stage_en[0]) r_v[0] <= i_in_valid;
            if (stage_en[1]) r_v[1] <= r_v[0];
            if (stage_en[2]) r_v[2] <= r_v[1];
            if (stage_en[3]) r_v[3] <= r_v[2];
        end
    end

    t_ordinal ord_first;
    t_ordinal ord_second;

    dd_ordinal u_ord_first (
        .i_clk     (i_clk),
        .i_en      (stage_en[2:0]),
        .i_year    (i_first_year),
        .i_month   (i_first_month),
        .i_day     (i_first_day),
        .o_ordinal (ord_first)
    );

    dd_ordinal u_ord_second (
        .i_clk     (i_clk),
        .i_en      (stage_en[2:0]),
        .i_year    (i_second_year),
        .i_month   (i_second_month),
        .i_day     (i_second_day),
        .o_ordinal (ord_second)
    );

    t_ordinal               diff;
    logic [COUNT_W-1:0]     r_day_count;

    assign diff = (ord_first >= ord_second) ? (ord_first - ord_second)
                                            : (ord_second - ord_first);

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            r_day_count <= diff[ORD_W-1] ? COUNT_MAX : diff[COUNT_W-1:0];
        end
    end

    assign o_day_count = r_day_count;

`ifndef SYNTHESIS
    logic in_beat;
    logic out_beat;

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_beat = o_out_valid && i_out_ready;

    // Beats in flight change only by the beats taken in and handed out.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_v) == $past($countones(r_v)) + $past(int'(in_beat))
                  - $past(int'(out_beat))))
        else $error("pipeline occupancy does not match the beats moved");

    // With the output stage empty, the pipe must take a new beat.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[3] |-> o_in_ready)
        else $error("input stalled although the output stage is empty");

    // A full pipe behind a stalled receiver must refuse input.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while the full pipe is stalled");

    // A stalled third stage keeps its beat.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[2] && !stage_en[3]) |=> r_v[2])
        else $error("stalled beat lost in the third stage");
`endif

endmodule

[tb/tb_date_difference_in_days_core.sv]
`timescale 1ns / 1ps

module tb_date_difference_in_days_core;

    import dd_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int RANDOM_BEATS = 400;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_cal_date;

    typedef struct {
        t_cal_date          a;
        t_cal_date          b;
        bit                 typed;
        logic [COUNT_W-1:0] want;
    } t_plan_row;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_ready;
    logic [YEAR_W-1:0]    i_first_year   = '0;
    logic [MONTH_W-1:0]   i_first_month  = '0;
    logic [DAY_W-1:0]     i_first_day    = '0;
    logic [YEAR_W-1:0]    i_second_year  = '0;
    logic [MONTH_W-1:0]   i_second_month = '0;
    logic [DAY_W-1:0]     i_second_day   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready    = 1'b0;
    logic [COUNT_W-1:0]   o_day_count;

    logic [COUNT_W-1:0]   beat_want = '0;
    logic [COUNT_W-1:0]   count_head;
    logic [COUNT_W-1:0]   counts_due [$];
    t_plan_row            plan [$];
    int                   errors    = 0;
    int                   cycles    = 0;
    bit                   calm      = 1'b0;
    bit                   hold_req  = 1'b0;

    date_difference_in_days_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_first_year   (i_first_year),
        .i_first_month  (i_first_month),
        .i_first_day    (i_first_day),
        .i_second_year  (i_second_year),
        .i_second_month (i_second_month),
        .i_second_day   (i_second_day),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_day_count    (o_day_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_cal_date dt(input int y, input int m, input int d);
        t_cal_date r;
        r.year  = y[YEAR_W-1:0];
        r.month = m[MONTH_W-1:0];
        r.day   = d[DAY_W-1:0];
        return r;
    endfunction

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_len(input int unsigned m);
        if (m == 2) begin
            return 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    // Ordinal counted from the start of year zero; no range check on month or day.
    function automatic int unsigned day_number(input t_cal_date d);
        int unsigned y;
        int unsigned leaps;
        int unsigned doy;
        y     = d.year;
        leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        doy   = d.day;
        for (int unsigned k = 1; k < d.month && k <= 12; k++) begin
            doy += month_len(k);
        end
        if (d.month >= 3 && is_leap(y)) begin
            doy += 1;
        end
        return 365 * y + leaps + doy;
    endfunction

    function automatic logic [COUNT_W-1:0] days_between(input t_cal_date a, input t_cal_date b);
        int unsigned na;
        int unsigned nb;
        int unsigned span;
        na   = day_number(a);
        nb   = day_number(b);
        span = (na >= nb) ? na - nb : nb - na;
        if (span > COUNT_MAX) begin
            span = COUNT_MAX;
        end
        return span[COUNT_W-1:0];
    endfunction

    // Mostly well-formed dates; now and then any bit pattern the ports allow.
    function automatic t_cal_date random_date(input bit wild);
        t_cal_date r;
        int unsigned top;
        if (wild) begin
            r.year  = YEAR_W'($urandom);
            r.month = MONTH_W'($urandom);
            r.day   = DAY_W'($urandom);
        end else begin
            r.year  = YEAR_W'($urandom_range(1, 9999));
            r.month = MONTH_W'($urandom_range(1, 12));
            top     = month_len(r.month) + ((r.month == 2 && is_leap(r.year)) ? 1 : 0);
            r.day   = DAY_W'($urandom_range(1, top));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                   input logic [COUNT_W-1:0] want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic send_dates(input t_cal_date a, input t_cal_date b,
                              input logic [COUNT_W-1:0] want);
        int gap;
        if (!calm && !hold_req && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_first_year   <= a.year;
        i_first_month  <= a.month;
        i_first_day    <= a.day;
        i_second_year  <= b.year;
        i_second_month <= b.month;
        i_second_day   <= b.day;
        beat_want      <= want;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every result in flight has come back.
    task automatic drain_pause();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (counts_due.size() != 0);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb_date_difference_in_days_core failed");
            $finish;
        end
    end

    // Results are checked before new beats are queued, so a stray result
    // never consumes the expectation of a beat taken in the same cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (counts_due.size() == 0) begin
                report_mismatch("day_count with no beat pending", o_day_count, '0);
            end else begin
                count_head = counts_due.pop_front();
                if (o_day_count !== count_head) begin
                    report_mismatch("day_count", o_day_count, count_head);
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            counts_due.push_back(beat_want);
        end
    end

    initial begin
        int held;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) begin
                    @(negedge i_clk);
                end
                hold_req = 1'b0;
            end else if (calm) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 37);
            end
        end
    end

    initial begin
        t_cal_date a;
        t_cal_date b;
        int        pick;

        plan.push_back('{dt(2024, 3, 15),  dt(2024, 3, 15),  1'b1, 22'd0});
        plan.push_back('{dt(0, 0, 0),      dt(9999, 12, 31), 1'b1, 22'd3652425});
        plan.push_back('{dt(9999, 12, 31), dt(0, 0, 0),      1'b1, 22'd3652425});
        plan.push_back('{dt(1, 1, 1),      dt(9999, 12, 31), 1'b1, 22'd3652058});
        plan.push_back('{dt(0, 0, 0),      dt(16383, 15, 31), 1'b1, COUNT_MAX});
        plan.push_back('{dt(16383, 15, 31), dt(0, 0, 0),     1'b1, COUNT_MAX});
        plan.push_back('{dt(16383, 15, 31), dt(16383, 15, 31), 1'b1, 22'd0});
        // February 31 lands on March 3; day zero is the last day of the month before.
        plan.push_back('{dt(2023, 2, 31),  dt(2023, 3, 3),   1'b1, 22'd0});
        plan.push_back('{dt(2023, 3, 0),   dt(2023, 2, 28),  1'b1, 22'd0});
        plan.push_back('{dt(2023, 0, 5),   dt(2023, 1, 5),   1'b1, 22'd0});
        plan.push_back('{dt(2023, 13, 1),  dt(2024, 1, 1),   1'b1, 22'd0});
        plan.push_back('{dt(2024, 15, 0),  dt(2024, 12, 31), 1'b1, 22'd0});
        plan.push_back('{dt(0, 2, 29),     dt(0, 3, 1),      1'b1, 22'd1});
        plan.push_back('{dt(1900, 2, 28),  dt(1900, 3, 1),   1'b1, 22'd1});
        plan.push_back('{dt(2000, 2, 28),  dt(2000, 3, 1),   1'b1, 22'd2});
        plan.push_back('{dt(2100, 2, 28),  dt(2100, 3, 1),   1'b1, 22'd1});
        plan.push_back('{dt(2024, 2, 28),  dt(2024, 3, 1),   1'b1, 22'd2});
        plan.push_back('{dt(2023, 1, 1),   dt(2024, 1, 1),   1'b1, 22'd365});
        plan.push_back('{dt(2025, 1, 1),   dt(2024, 1, 1),   1'b1, 22'd366});
        plan.push_back('{dt(9999, 12, 31), dt(10000, 1, 1),  1'b1, 22'd1});
        plan.push_back('{dt(0, 0, 0),      dt(11484, 1, 1),  1'b0, 22'd0});
        plan.push_back('{dt(11483, 12, 31), dt(0, 0, 0),     1'b0, 22'd0});
        plan.push_back('{dt(1970, 1, 1),   dt(2038, 1, 19),  1'b0, 22'd0});
        plan.push_back('{dt(2024, 15, 31), dt(0, 15, 31),    1'b0, 22'd0});
        plan.push_back('{dt(5000, 7, 0),   dt(1, 1, 31),     1'b0, 22'd0});

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) begin
            send_dates(plan[k].a, plan[k].b,
                       plan[k].typed ? plan[k].want : days_between(plan[k].a, plan[k].b));
        end
        drain_pause();

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            calm = (n >= 200 && n < 300);
            if (n == 120) begin
                hold_req = 1'b1;
            end
            if (n == 260) begin
                drain_pause();
            end
            pick = $urandom_range(99);
            a    = random_date(pick < 25);
            b    = random_date(pick < 15);
            // Pairs close together exercise small spans and leap-day edges.
            if (pick >= 25 && pick < 55) begin
                b.year = YEAR_W'(a.year + $urandom_range(0, 2));
            end
            send_dates(a, b, days_between(a, b));
        end

        i_in_valid <= 1'b0;
        while (counts_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
        if (counts_due.size() != 0) begin
            report_mismatch("beats left without a result", '0, COUNT_W'(counts_due.size()));
        end
        if (errors == 0) begin
            $display("tb_date_difference_in_days_core passed");
        end else begin
            $display("tb_date_difference_in_days_core failed");
        end
        $finish;
    end

endmodule
